@@ sv/look_at_view_matrix_defines.svh @@
// assertion macros for the look-at view matrix block
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define LAVM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while in reset
`define LAVM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lavm_pkg.sv @@
// shared types, constants and latency helper for the look-at view matrix block
package lavm_pkg;

    // default fractional bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;
    // width of every input and output element
    localparam int DATA_W = 32;
    // block-scaled magnitude width inside the normalizer
    localparam int SCALE_W = 30;
    // left-normalize steps (32, 16, 8, 4, 2, 1)
    localparam int NORM_SHIFTS = 6;
    // square root steps over the 62-bit sum of squares
    localparam int SQRT_STEPS = SCALE_W + 1;

    typedef logic [1:0] row_idx_t;

    // matrix row codes
    localparam row_idx_t ROW_SIDE = 2'd0;
    localparam row_idx_t ROW_UP   = 2'd1;
    localparam row_idx_t ROW_FWD  = 2'd2;
    localparam row_idx_t ROW_LAST = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] eye_x;
        logic signed [DATA_W-1:0] eye_y;
        logic signed [DATA_W-1:0] eye_z;
        logic signed [DATA_W-1:0] target_x;
        logic signed [DATA_W-1:0] target_y;
        logic signed [DATA_W-1:0] target_z;
        logic signed [DATA_W-1:0] up_x;
        logic signed [DATA_W-1:0] up_y;
        logic signed [DATA_W-1:0] up_z;
    } camera_t;

    typedef struct packed {
        row_idx_t                 row_index;
        logic signed [DATA_W-1:0] elem0;
        logic signed [DATA_W-1:0] elem1;
        logic signed [DATA_W-1:0] elem2;
        logic signed [DATA_W-1:0] elem3;
        logic                     degenerate;
        logic                     last_row;
    } row_t;

    // pipeline depth of one vector normalizer
    function automatic int norm_lat(input int frac_bits);
        return NORM_SHIFTS + SQRT_STEPS + frac_bits + 6;
    endfunction

endpackage

@@ sv/look_at_view_matrix.sv @@
// look-at view matrix top level: basis pipeline and four-row output serializer
//
//   channel   dir  handshake                beat
//   camera    in   camera_valid / stall     eye, target, up (camera_t)
//   row       out  row_valid / row_stall    one matrix row (row_t)
//
// A camera beat passes the forward and up normalizers, the side normalizer and
// the translation stages to the row register, in Q16.16 at the default FRAC_BITS;
// its four rows then leave one per cycle while row_stall is low, row 0 first.
// The output serializer sets the rate; the pipeline behind it holds while the
// serializer still has rows to hand out, so nothing is dropped or repeated.
// Reset clears only valid bits, normalizer control words and the row counter.
`include "look_at_view_matrix_defines.svh"
module look_at_view_matrix #(
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              camera_valid,
    output logic              camera_stall,
    input  lavm_pkg::camera_t camera,
    output logic              row_valid,
    input  logic              row_stall,
    output lavm_pkg::row_t    row
);
    import lavm_pkg::*;

    localparam int UW  = FRAC_BITS + 2;
    localparam int FW  = DATA_W + 1;
    localparam int SW  = 2 * FRAC_BITS + 3;
    localparam int PW2 = 2 * UW;
    localparam int EPW = UW + DATA_W;
    localparam int DW  = EPW + 2;
    localparam int TMW = PW2 + 1 - FRAC_BITS;
    localparam int DMW = DW + 1 - FRAC_BITS;
    localparam int NL  = norm_lat(FRAC_BITS);
    localparam logic [PW2:0]       HALF_T = (PW2+1)'(1) << (FRAC_BITS - 1);
    localparam logic [DW:0]        HALF_D = (DW+1)'(1) << (FRAC_BITS - 1);
    localparam logic [TMW-1:0]     ONE_T  = TMW'(1) << FRAC_BITS;
    localparam logic [DMW-1:0]     POS_MAX = DMW'(32'h7FFF_FFFF);
    localparam logic [DMW-1:0]     NEG_MAX = DMW'(1) << (DATA_W - 1);
    localparam logic [DATA_W-1:0]  ONE_32 = DATA_W'(1) << FRAC_BITS;

    logic adv;

    // input stage
    logic signed [DATA_W-1:0] cam_eye [3];
    logic signed [DATA_W-1:0] cam_tgt [3];
    logic signed [DATA_W-1:0] cam_up  [3];
    logic                     t0_v_reg;
    logic signed [DATA_W-1:0] eye_t0_reg [3];
    logic signed [FW-1:0]     fwd_t0_reg [3];
    logic signed [DATA_W-1:0] up_t0_reg  [3];

    // first normalizers
    logic                     vf;
    logic                     vu;
    logic                     nzf;
    logic                     nzu;
    logic signed [UW-1:0]     fu [3];
    logic signed [UW-1:0]     uu [3];
    logic signed [DATA_W-1:0] eye1_reg [NL][3];

    // side cross product
    logic                     s1_v_reg;
    logic                     s2_v_reg;
    logic signed [PW2-1:0]    ps_reg [6];
    logic signed [DATA_W-1:0] eye_s1_reg [3];
    logic signed [UW-1:0]     fu_s1_reg  [3];
    logic                     ok_s1_reg;
    logic signed [SW-1:0]     sraw_reg [3];
    logic signed [DATA_W-1:0] eye_s2_reg [3];
    logic signed [UW-1:0]     fu_s2_reg  [3];
    logic                     ok_s2_reg;

    // side normalizer
    logic                     vs;
    logic                     nzs;
    logic signed [UW-1:0]     su [3];
    logic signed [DATA_W-1:0] eye2_reg [NL][3];
    logic signed [UW-1:0]     fu2_reg  [NL][3];
    logic                     ok2_reg  [NL];

    // true up and rows
    logic                     r1_v_reg;
    logic                     r2_v_reg;
    logic                     r3_v_reg;
    logic signed [PW2-1:0]    pt_reg [6];
    logic signed [UW-1:0]     su_r1_reg [3];
    logic signed [UW-1:0]     fu_r1_reg [3];
    logic signed [DATA_W-1:0] eye_r1_reg [3];
    logic                     ok_r1_reg;
    logic signed [PW2-1:0]    traw_reg [3];
    logic signed [UW-1:0]     su_r2_reg [3];
    logic signed [UW-1:0]     fu_r2_reg [3];
    logic signed [DATA_W-1:0] eye_r2_reg [3];
    logic                     ok_r2_reg;
    logic [PW2-1:0]           tmag [3];
    logic [PW2:0]             tsum [3];
    logic [TMW-1:0]           tm   [3];
    logic signed [UW-1:0]     tup  [3];
    logic signed [UW-1:0]     rw_r3_reg [3][3];
    logic signed [DATA_W-1:0] eye_r3_reg [3];
    logic                     ok_r3_reg;

    // translation dot products
    logic                     d1_v_reg;
    logic                     d2_v_reg;
    logic                     d3_v_reg;
    logic signed [EPW-1:0]    dp_reg [3][3];
    logic signed [UW-1:0]     rw_d1_reg [3][3];
    logic                     ok_d1_reg;
    logic signed [DW-1:0]     dsum_reg [3];
    logic signed [UW-1:0]     rw_d2_reg [3][3];
    logic                     ok_d2_reg;
    logic [DW-1:0]            dmag [3];
    logic [DW:0]              dround [3];
    logic [DMW-1:0]           dm [3];
    logic signed [DATA_W-1:0] tr [3];
    logic signed [DATA_W-1:0] e_next [3][4];
    logic signed [DATA_W-1:0] e_d3_reg [3][4];
    logic                     deg_d3_reg;

    // row serializer
    logic                     ser_v_reg;
    row_idx_t                 cnt_reg;
    logic signed [DATA_W-1:0] ser_e_reg [3][4];
    logic                     ser_deg_reg;

    // the pipeline moves whenever the serializer frees up
    assign adv          = !ser_v_reg || (cnt_reg == ROW_LAST && !row_stall);
    assign camera_stall = !adv;

    assign cam_eye[0] = camera.eye_x;
    assign cam_eye[1] = camera.eye_y;
    assign cam_eye[2] = camera.eye_z;
    assign cam_tgt[0] = camera.target_x;
    assign cam_tgt[1] = camera.target_y;
    assign cam_tgt[2] = camera.target_z;
    assign cam_up[0]  = camera.up_x;
    assign cam_up[1]  = camera.up_y;
    assign cam_up[2]  = camera.up_z;

    // valid bits of the top-level stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            r1_v_reg <= 1'b0;
            r2_v_reg <= 1'b0;
            r3_v_reg <= 1'b0;
            d1_v_reg <= 1'b0;
            d2_v_reg <= 1'b0;
            d3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            t0_v_reg <= camera_valid;
            s1_v_reg <= vf;
            s2_v_reg <= s1_v_reg;
            r1_v_reg <= vs;
            r2_v_reg <= r1_v_reg;
            r3_v_reg <= r2_v_reg;
            d1_v_reg <= r3_v_reg;
            d2_v_reg <= d1_v_reg;
            d3_v_reg <= d2_v_reg;
        end
    end

    // forward vector
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                eye_t0_reg[i] <= cam_eye[i];
                fwd_t0_reg[i] <= FW'(cam_tgt[i]) - FW'(cam_eye[i]);
                up_t0_reg[i]  <= cam_up[i];
            end
        end
    end

    lavm_norm #(
        .IW        (FW),
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (t0_v_reg),
        .in_vec    (fwd_t0_reg),
        .out_valid (vf),
        .out_nz    (nzf),
        .out_unit  (fu)
    );

    lavm_norm #(
        .IW        (DATA_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (t0_v_reg),
        .in_vec    (up_t0_reg),
        .out_valid (vu),
        .out_nz    (nzu),
        .out_unit  (uu)
    );

    // eye rides alongside the first normalizers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            eye1_reg[0] <= eye_t0_reg;
            for (int s = 1; s < NL; s++)
            begin
                eye1_reg[s] <= eye1_reg[s-1];
            end
        end
    end

    // side = forward x up, products then differences
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ps_reg[0]  <= fu[1] * uu[2];
            ps_reg[1]  <= fu[2] * uu[1];
            ps_reg[2]  <= fu[2] * uu[0];
            ps_reg[3]  <= fu[0] * uu[2];
            ps_reg[4]  <= fu[0] * uu[1];
            ps_reg[5]  <= fu[1] * uu[0];
            eye_s1_reg <= eye1_reg[NL-1];
            fu_s1_reg  <= fu;
            ok_s1_reg  <= nzf && nzu;
            for (int i = 0; i < 3; i++)
            begin
                sraw_reg[i] <= SW'(ps_reg[2*i] - ps_reg[2*i+1]);
            end
            eye_s2_reg <= eye_s1_reg;
            fu_s2_reg  <= fu_s1_reg;
            ok_s2_reg  <= ok_s1_reg;
        end
    end

    lavm_norm #(
        .IW        (SW),
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s2_v_reg),
        .in_vec    (sraw_reg),
        .out_valid (vs),
        .out_nz    (nzs),
        .out_unit  (su)
    );

    // eye, forward and flags ride alongside the side normalizer
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            eye2_reg[0] <= eye_s2_reg;
            fu2_reg[0]  <= fu_s2_reg;
            ok2_reg[0]  <= ok_s2_reg;
            for (int s = 1; s < NL; s++)
            begin
                eye2_reg[s] <= eye2_reg[s-1];
                fu2_reg[s]  <= fu2_reg[s-1];
                ok2_reg[s]  <= ok2_reg[s-1];
            end
        end
    end

    // true up = side x forward, products then differences
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_reg[0]  <= su[1] * fu2_reg[NL-1][2];
            pt_reg[1]  <= su[2] * fu2_reg[NL-1][1];
            pt_reg[2]  <= su[2] * fu2_reg[NL-1][0];
            pt_reg[3]  <= su[0] * fu2_reg[NL-1][2];
            pt_reg[4]  <= su[0] * fu2_reg[NL-1][1];
            pt_reg[5]  <= su[1] * fu2_reg[NL-1][0];
            su_r1_reg  <= su;
            fu_r1_reg  <= fu2_reg[NL-1];
            eye_r1_reg <= eye2_reg[NL-1];
            ok_r1_reg  <= ok2_reg[NL-1] && nzs;
            for (int i = 0; i < 3; i++)
            begin
                traw_reg[i] <= pt_reg[2*i] - pt_reg[2*i+1];
            end
            su_r2_reg  <= su_r1_reg;
            fu_r2_reg  <= fu_r1_reg;
            eye_r2_reg <= eye_r1_reg;
            ok_r2_reg  <= ok_r1_reg;
        end
    end

    // round true up half away from zero and clamp to one
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tmag[i] = traw_reg[i][PW2-1] ? PW2'(-traw_reg[i]) : PW2'(traw_reg[i]);
            tsum[i] = (PW2+1)'(tmag[i]) + HALF_T;
            tm[i]   = tsum[i][PW2:FRAC_BITS];
            if (tm[i] > ONE_T)
            begin
                tm[i] = ONE_T;
            end
            tup[i] = traw_reg[i][PW2-1] ? -$signed(UW'(tm[i])) : $signed(UW'(tm[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rw_r3_reg[ROW_SIDE][i] <= su_r2_reg[i];
                rw_r3_reg[ROW_UP][i]   <= tup[i];
                rw_r3_reg[ROW_FWD][i]  <= -fu_r2_reg[i];
            end
            eye_r3_reg <= eye_r2_reg;
            ok_r3_reg  <= ok_r2_reg;
        end
    end

    // row . eye: products, then sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dp_reg[r][i] <= rw_r3_reg[r][i] * eye_r3_reg[i];
                end
                dsum_reg[r] <= DW'(dp_reg[r][0]) + DW'(dp_reg[r][1]) + DW'(dp_reg[r][2]);
            end
            rw_d1_reg <= rw_r3_reg;
            ok_d1_reg <= ok_r3_reg;
            rw_d2_reg <= rw_d1_reg;
            ok_d2_reg <= ok_d1_reg;
        end
    end

    // translation: round, negate, saturate; zero everything when degenerate
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            dmag[r]   = dsum_reg[r][DW-1] ? DW'(-dsum_reg[r]) : DW'(dsum_reg[r]);
            dround[r] = (DW+1)'(dmag[r]) + HALF_D;
            dm[r]     = dround[r][DW:FRAC_BITS];
            if (dsum_reg[r][DW-1])
            begin
                tr[r] = (dm[r] > POS_MAX) ? $signed(32'h7FFF_FFFF) : $signed(DATA_W'(dm[r]));
            end
            else
            begin
                tr[r] = (dm[r] > NEG_MAX) ? $signed(32'h8000_0000)
                                          : $signed(DATA_W'(-$signed({1'b0, dm[r]})));
            end
            for (int i = 0; i < 3; i++)
            begin
                e_next[r][i] = ok_d2_reg ? DATA_W'(rw_d2_reg[r][i]) : '0;
            end
            e_next[r][3] = ok_d2_reg ? tr[r] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_d3_reg   <= e_next;
            deg_d3_reg <= !ok_d2_reg;
        end
    end

    // serializer control: hand out four rows per camera
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_v_reg <= 1'b0;
            cnt_reg   <= ROW_SIDE;
        end
        else if (adv)
        begin
            ser_v_reg <= d3_v_reg;
            cnt_reg   <= ROW_SIDE;
        end
        else if (!row_stall)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ser_e_reg   <= e_d3_reg;
            ser_deg_reg <= deg_d3_reg;
        end
    end

    // current row beat
    assign row_valid = ser_v_reg;
    always_comb
    begin
        row.row_index  = cnt_reg;
        row.degenerate = ser_deg_reg;
        row.last_row   = (cnt_reg == ROW_LAST);
        unique case (cnt_reg)
            ROW_SIDE, ROW_UP, ROW_FWD:
            begin
                row.elem0 = ser_e_reg[cnt_reg][0];
                row.elem1 = ser_e_reg[cnt_reg][1];
                row.elem2 = ser_e_reg[cnt_reg][2];
                row.elem3 = ser_e_reg[cnt_reg][3];
            end
            ROW_LAST:
            begin
                row.elem0 = '0;
                row.elem1 = '0;
                row.elem2 = '0;
                row.elem3 = ser_deg_reg ? '0 : $signed(ONE_32);
            end
            default:
            begin
                row.elem0 = '0;
                row.elem1 = '0;
                row.elem2 = '0;
                row.elem3 = '0;
            end
        endcase
    end

    `LAVM_ASSERT_IMP(a_norm_align, clk, rst_n, 1'b1, vf == vu, "fwd and up normalizers out of step")
    `LAVM_ASSERT_IMP(a_stall_busy, clk, rst_n, camera_stall, row_valid, "camera stalled with serializer empty")
    `LAVM_ASSERT_NXT(a_row_cont, clk, rst_n, row_valid && !row_stall && !row.last_row, row_valid && row.row_index == $past(row.row_index) + 2'd1, "matrix rows broken off")
    `LAVM_ASSERT_NXT(a_row_first, clk, rst_n, row_valid && !row_stall && row.last_row, !row_valid || row.row_index == ROW_SIDE, "new matrix not starting at row 0")
    `LAVM_ASSERT_IMP(a_deg_zero, clk, rst_n, row_valid && row.degenerate, row.elem0 == 0 && row.elem1 == 0 && row.elem2 == 0 && row.elem3 == 0, "degenerate row not zero")

endmodule

@@ sv/lavm_norm.sv @@
// pipelined 3-vector normalizer: block scale, square root, per-bit division
module lavm_norm #(
    parameter int IW        = 33,
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic signed [IW-1:0]        in_vec [3],
    output logic                        out_valid,
    output logic                        out_nz,
    output logic signed [FRAC_BITS+1:0] out_unit [3]
);
    import lavm_pkg::*;

    localparam int UW     = FRAC_BITS + 2;
    localparam int QW     = FRAC_BITS + 1;
    localparam int SQW    = 2 * SCALE_W;
    localparam int RW     = SQW + 2;
    localparam int NSQ    = SQRT_STEPS;
    localparam int LW     = NSQ;
    localparam int PRW    = LW + 1;
    localparam int NW     = SCALE_W + QW;
    localparam int NSH    = NORM_SHIFTS;
    localparam int LAT    = norm_lat(FRAC_BITS);

    typedef struct packed {
        logic       valid;
        logic       nz;
        logic [2:0] neg;
    } norm_ctl_t;

    norm_ctl_t         ctl_reg [LAT];
    norm_ctl_t         ctl_next;

    logic [IW-1:0]     mag_a [3];
    logic [IW-1:0]     mx_a;
    logic [IW-1:0]     shm_reg [NSH+1][3];
    logic [IW-1:0]     shx_reg [NSH+1];
    logic [SCALE_W-1:0] sc_a [3];
    logic [SCALE_W-1:0] scd_reg [NSQ+2][3];
    logic [SQW-1:0]    sq_reg [3];
    logic [RW-1:0]     sum_reg;
    logic [RW-1:0]     x_reg [NSQ-1];
    logic [RW-1:0]     r_reg [NSQ];
    logic [LW-1:0]     len_d;
    logic [NW-1:0]     n_d [3];
    logic [PRW-1:0]    rem_reg [QW][3];
    logic [QW-1:0]     nlo_reg [QW][3];
    logic [LW-1:0]     len_reg [QW];
    logic [QW-1:0]     q_reg [1:QW][3];
    logic signed [UW-1:0] unit_reg [3];

    // magnitudes, signs and largest magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_a[i] = in_vec[i][IW-1] ? IW'(-in_vec[i]) : IW'(in_vec[i]);
        end
        mx_a = mag_a[0];
        if (mag_a[1] > mx_a)
        begin
            mx_a = mag_a[1];
        end
        if (mag_a[2] > mx_a)
        begin
            mx_a = mag_a[2];
        end
        ctl_next.valid = in_valid;
        ctl_next.nz    = (mx_a != '0);
        ctl_next.neg   = {in_vec[2][IW-1], in_vec[1][IW-1], in_vec[0][IW-1]};
    end

    // control travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LAT; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else if (adv)
        begin
            ctl_reg[0] <= ctl_next;
            for (int s = 1; s < LAT; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            shx_reg[0] <= mx_a;
            for (int i = 0; i < 3; i++)
            begin
                shm_reg[0][i] <= mag_a[i];
            end
        end
    end

    // left-normalize the largest magnitude, same shift on all three
    for (genvar k = 1; k <= NSH; k++)
    begin : g_shift
        localparam int STEP = 1 << (NSH - k);
        logic hit;
        assign hit = (shx_reg[k-1][IW-1 -: STEP] == '0);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                shx_reg[k] <= hit ? (shx_reg[k-1] << STEP) : shx_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    shm_reg[k][i] <= hit ? (shm_reg[k-1][i] << STEP) : shm_reg[k-1][i];
                end
            end
        end
    end

    // top bits give the scaled magnitudes; square them
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sc_a[i] = shm_reg[NSH][i][IW-1 -: SCALE_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]     <= SQW'(sc_a[i]) * SQW'(sc_a[i]);
                scd_reg[0][i] <= sc_a[i];
                scd_reg[1][i] <= scd_reg[0][i];
            end
            sum_reg <= RW'(sq_reg[0]) + RW'(sq_reg[1]) + RW'(sq_reg[2]);
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        localparam logic [RW-1:0] BITV = RW'(1) << (RW - 2 - 2 * k);
        logic [RW-1:0] x_in;
        logic [RW-1:0] r_in;
        logic [RW-1:0] trial;
        logic          take;
        if (k == 0)
        begin : g_first
            assign x_in = sum_reg;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign x_in = x_reg[k-1];
            assign r_in = r_reg[k-1];
        end
        assign trial = r_in + BITV;
        assign take  = (x_in >= trial);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg[k] <= take ? ((r_in >> 1) + BITV) : (r_in >> 1);
                for (int i = 0; i < 3; i++)
                begin
                    scd_reg[k+2][i] <= scd_reg[k+1][i];
                end
            end
        end
        if (k < NSQ - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x_reg[k] <= take ? (x_in - trial) : x_in;
                end
            end
        end
    end

    // rounded dividend: scaled magnitude times one plus half the length
    always_comb
    begin
        len_d = r_reg[NSQ-1][LW-1:0];
        for (int i = 0; i < 3; i++)
        begin
            n_d[i] = NW'({scd_reg[NSQ+1][i], {FRAC_BITS{1'b0}}}) + NW'(len_d >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            len_reg[0] <= len_d;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= PRW'(n_d[i][NW-1:QW]);
                nlo_reg[0][i] <= n_d[i][QW-1:0];
            end
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        logic [PRW:0]  rem2 [3];
        logic          ge   [3];
        logic [QW-1:0] q_in [3];
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem2[i] = {rem_reg[j-1][i], nlo_reg[j-1][i][QW-1]};
                ge[i]   = (rem2[i] >= (PRW+1)'(len_reg[j-1]));
            end
        end
        if (j == 1)
        begin : g_q0
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q_in[i] = '0;
                end
            end
        end
        else
        begin : g_qn
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q_in[i] = q_reg[j-1][i];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q_reg[j][i] <= {q_in[i][QW-2:0], ge[i]};
                end
            end
        end
        if (j < QW)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    len_reg[j] <= len_reg[j-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        rem_reg[j][i] <= ge[i] ? PRW'(rem2[i] - (PRW+1)'(len_reg[j-1]))
                                               : PRW'(rem2[i]);
                        nlo_reg[j][i] <= nlo_reg[j-1][i] << 1;
                    end
                end
            end
        end
    end

    // restore the signs
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                unit_reg[i] <= ctl_reg[LAT-2].neg[i] ? -$signed({1'b0, q_reg[QW][i]})
                                                     : $signed({1'b0, q_reg[QW][i]});
            end
        end
    end

    assign out_valid = ctl_reg[LAT-1].valid;
    assign out_nz    = ctl_reg[LAT-1].nz;
    assign out_unit  = unit_reg;

endmodule
